@@ sv/fepl_pkg.sv @@
// ----------------------------------------------------------------------------
// fepl_pkg
// Widths, register indexes and shared types of the flat-earth path length
// block.
// ----------------------------------------------------------------------------
package fepl_pkg;

    localparam int LAT_W   = 31;            // latitude field
    localparam int LON_W   = 32;            // longitude field
    localparam int SCALE_W = 32;            // per-degree scale registers
    localparam int MAG_W   = 33;            // magnitude of a coordinate difference
    localparam int PROD_W  = MAG_W + SCALE_W;
    localparam int DIST_W  = 51;            // magnitude of dy or dx
    localparam int LO_W    = 26;            // low half of dy or dx
    localparam int HI_W    = DIST_W - LO_W; // high half of dy or dx
    localparam int PP_W    = 2 * LO_W;      // widest partial product
    localparam int SQ_W    = 103;           // dy*dy + dx*dx
    localparam int ROOT_W  = 52;            // floor of the square root
    localparam int TOTAL_W = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LON_SCALE = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } root_status_t;

endpackage

@@ sv/fepl_mul.sv @@
// ----------------------------------------------------------------------------
// fepl_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module fepl_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fepl_pkg::MAG_W-1:0]   a,
    input  logic [fepl_pkg::SCALE_W-1:0] b,
    output logic [fepl_pkg::PROD_W-1:0]  p
);

    logic [fepl_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= fepl_pkg::PROD_W'(a) * fepl_pkg::PROD_W'(b);
        end
    end

    assign p = p_reg;

endmodule

@@ sv/fepl_sqrt.sv @@
// ----------------------------------------------------------------------------
// fepl_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fepl_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fepl_pkg::SQ_W-1:0]     radicand,
    output logic [fepl_pkg::ROOT_W-1:0]   root,
    output fepl_pkg::root_status_t        status
);

    localparam int SQP_W = 2 * fepl_pkg::ROOT_W;
    localparam int REM_W = fepl_pkg::ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;
    localparam int CNT_W = $clog2(fepl_pkg::ROOT_W);

    logic [SQP_W-1:0]            n_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [fepl_pkg::ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]            count_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [TRY_W-1:0] rem_shift;
    logic [TRY_W-1:0] trial;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg, n_reg[SQP_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg     <= SQP_W'(radicand);
                rem_reg   <= '0;
                root_reg  <= '0;
                count_reg <= CNT_W'(fepl_pkg::ROOT_W - 1);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                n_reg <= {n_reg[SQP_W-3:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= REM_W'(rem_shift - trial);
                    root_reg <= {root_reg[fepl_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift[REM_W-1:0];
                    root_reg <= {root_reg[fepl_pkg::ROOT_W-2:0], 1'b0};
                end
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ sv/flat_earth_path_length.sv @@
// ----------------------------------------------------------------------------
// flat_earth_path_length
// Sums the flat-earth length of a stream of points and reports it per path.
// ----------------------------------------------------------------------------
// A point that follows another point of the same path passes through the beat
// itself, the shared multiplier (two scalings and six partial products of
// dy*dy + dx*dx), the square-root unit, which retires one root bit per cycle
// over 52 bits, and a step that adds the root to the total. A last point then
// loads the result register; the next point is taken while that result still
// waits.
module flat_earth_path_length #(
    parameter int COORD_FRAC_BITS = 23
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fepl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fepl_pkg::SCALE_W-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // latitude[30:0], longitude[62:31]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // total_distance[63:0]
    output logic                            m_tuser    // overflowed[0]
);

    localparam int SCALE_SHIFT = COORD_FRAC_BITS - 2;
    localparam int STEP_W      = 4;

    localparam logic [STEP_W-1:0] STEP_LAT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LON   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DY_LL = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DY_HL = 4'd3;
    localparam logic [STEP_W-1:0] STEP_DY_HH = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DX_LL = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DX_HL = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DX_HH = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd8;

    localparam logic [fepl_pkg::PROD_W-1:0] FRAC_MASK =
        (fepl_pkg::PROD_W'(1) << SCALE_SHIFT) - fepl_pkg::PROD_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    logic [fepl_pkg::SCALE_W-1:0]    lat_scale_reg;
    logic [fepl_pkg::SCALE_W-1:0]    lon_scale_reg;
    logic [fepl_pkg::LAT_W-1:0]      prev_lat_reg;
    logic [fepl_pkg::LON_W-1:0]      prev_lon_reg;
    logic                            have_prev_reg;
    logic [fepl_pkg::TOTAL_W-1:0]    total_reg;
    logic                            sat_reg;
    logic                            last_reg;
    logic [fepl_pkg::MAG_W-1:0]      mag_lat_reg;
    logic [fepl_pkg::MAG_W-1:0]      mag_lon_reg;
    logic                            neg_lat_reg;
    logic                            neg_lon_reg;
    logic [fepl_pkg::DIST_W-1:0]     dy_reg;
    logic [fepl_pkg::DIST_W-1:0]     dx_reg;
    logic [fepl_pkg::SQ_W-1:0]       acc_reg;
    logic [STEP_W-1:0]               step_reg;
    logic                            root_start_reg;
    logic                            out_valid_reg;
    logic [fepl_pkg::TOTAL_W-1:0]    out_total_reg;
    logic                            out_ovf_reg;

    logic [fepl_pkg::LAT_W-1:0]      in_lat;
    logic [fepl_pkg::LON_W-1:0]      in_lon;
    logic [fepl_pkg::MAG_W-1:0]      lat_diff;
    logic [fepl_pkg::MAG_W-1:0]      lon_diff;
    logic [fepl_pkg::MAG_W-1:0]      mul_a;
    logic [fepl_pkg::SCALE_W-1:0]    mul_b;
    logic [fepl_pkg::PROD_W-1:0]     mul_p;
    logic [fepl_pkg::PROD_W-1:0]     p_shift;
    logic                            dist_neg;
    logic                            frac_nz;
    logic [fepl_pkg::DIST_W-1:0]     step_dist;
    logic [fepl_pkg::SQ_W-1:0]       pp;
    logic [fepl_pkg::SQ_W-1:0]       term;
    logic [fepl_pkg::TOTAL_W:0]      sum;
    logic [fepl_pkg::ROOT_W-1:0]     root;
    fepl_pkg::root_status_t          root_status;
    logic                            in_beat;
    logic                            emit_go;

    assign in_lat  = s_tdata[fepl_pkg::LAT_W-1:0];
    assign in_lon  = s_tdata[fepl_pkg::LAT_W +: fepl_pkg::LON_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign emit_go  = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        lat_diff = fepl_pkg::MAG_W'($signed(in_lat)) - fepl_pkg::MAG_W'($signed(prev_lat_reg));
        lon_diff = fepl_pkg::MAG_W'($signed(in_lon)) - fepl_pkg::MAG_W'($signed(prev_lon_reg));
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_LAT:
            begin
                mul_a = mag_lat_reg;
                mul_b = lat_scale_reg;
            end
            STEP_LON:
            begin
                mul_a = mag_lon_reg;
                mul_b = lon_scale_reg;
            end
            STEP_DY_LL:
            begin
                mul_a = fepl_pkg::MAG_W'(dy_reg[fepl_pkg::LO_W-1:0]);
                mul_b = fepl_pkg::SCALE_W'(dy_reg[fepl_pkg::LO_W-1:0]);
            end
            STEP_DY_HL:
            begin
                mul_a = fepl_pkg::MAG_W'(dy_reg[fepl_pkg::DIST_W-1:fepl_pkg::LO_W]);
                mul_b = fepl_pkg::SCALE_W'(dy_reg[fepl_pkg::LO_W-1:0]);
            end
            STEP_DY_HH:
            begin
                mul_a = fepl_pkg::MAG_W'(dy_reg[fepl_pkg::DIST_W-1:fepl_pkg::LO_W]);
                mul_b = fepl_pkg::SCALE_W'(dy_reg[fepl_pkg::DIST_W-1:fepl_pkg::LO_W]);
            end
            STEP_DX_LL:
            begin
                mul_a = fepl_pkg::MAG_W'(dx_reg[fepl_pkg::LO_W-1:0]);
                mul_b = fepl_pkg::SCALE_W'(dx_reg[fepl_pkg::LO_W-1:0]);
            end
            STEP_DX_HL:
            begin
                mul_a = fepl_pkg::MAG_W'(dx_reg[fepl_pkg::DIST_W-1:fepl_pkg::LO_W]);
                mul_b = fepl_pkg::SCALE_W'(dx_reg[fepl_pkg::LO_W-1:0]);
            end
            STEP_DX_HH:
            begin
                mul_a = fepl_pkg::MAG_W'(dx_reg[fepl_pkg::DIST_W-1:fepl_pkg::LO_W]);
                mul_b = fepl_pkg::SCALE_W'(dx_reg[fepl_pkg::DIST_W-1:fepl_pkg::LO_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fepl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .a     (mul_a),
        .b     (mul_b),
        .p     (mul_p)
    );

    always_comb
    begin
        dist_neg  = (step_reg == STEP_LON) ? neg_lat_reg : neg_lon_reg;
        p_shift   = mul_p >> SCALE_SHIFT;
        frac_nz   = |(mul_p & FRAC_MASK);
        step_dist = p_shift[fepl_pkg::DIST_W-1:0] + fepl_pkg::DIST_W'(dist_neg && frac_nz);
        pp        = fepl_pkg::SQ_W'(mul_p[fepl_pkg::PP_W-1:0]);
        case (step_reg)
            STEP_DY_HL, STEP_DX_HL: term = pp;
            STEP_DY_HH, STEP_DX_HH: term = pp << (fepl_pkg::LO_W + 1);
            STEP_DX_LL, STEP_LAST:  term = pp << (2 * fepl_pkg::LO_W);
            default:                term = '0;
        endcase
        sum = {1'b0, total_reg} + (fepl_pkg::TOTAL_W + 1)'(root);
    end

    fepl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start_reg),
        .radicand (acc_reg),
        .root     (root),
        .status   (root_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_scale_reg <= '0;
            lon_scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fepl_pkg::CFG_LAT_SCALE: lat_scale_reg <= cfg_data;
                fepl_pkg::CFG_LON_SCALE: lon_scale_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_lat_reg   <= '0;
            prev_lon_reg   <= '0;
            have_prev_reg  <= 1'b0;
            total_reg      <= '0;
            sat_reg        <= 1'b0;
            last_reg       <= 1'b0;
            mag_lat_reg    <= '0;
            mag_lon_reg    <= '0;
            neg_lat_reg    <= 1'b0;
            neg_lon_reg    <= 1'b0;
            dy_reg         <= '0;
            dx_reg         <= '0;
            acc_reg        <= '0;
            step_reg       <= '0;
            root_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_total_reg  <= '0;
            out_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        prev_lat_reg  <= in_lat;
                        prev_lon_reg  <= in_lon;
                        have_prev_reg <= 1'b1;
                        last_reg      <= s_tlast;
                        neg_lat_reg   <= lat_diff[fepl_pkg::MAG_W-1];
                        neg_lon_reg   <= lon_diff[fepl_pkg::MAG_W-1];
                        mag_lat_reg   <= lat_diff[fepl_pkg::MAG_W-1] ? -lat_diff : lat_diff;
                        mag_lon_reg   <= lon_diff[fepl_pkg::MAG_W-1] ? -lon_diff : lon_diff;
                        acc_reg       <= '0;
                        step_reg      <= STEP_LAT;
                        if (have_prev_reg)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else if (s_tlast)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    acc_reg  <= acc_reg + term;
                    if (step_reg == STEP_LON)
                    begin
                        dy_reg <= step_dist;
                    end
                    if (step_reg == STEP_DY_LL)
                    begin
                        dx_reg <= step_dist;
                    end
                    if (step_reg == STEP_LAST)
                    begin
                        root_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    root_start_reg <= 1'b0;
                    if (root_status.done)
                    begin
                        state_reg <= ST_ACCUM;
                    end
                end
                ST_ACCUM:
                begin
                    if (sum[fepl_pkg::TOTAL_W])
                    begin
                        total_reg <= '1;
                        sat_reg   <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= sum[fepl_pkg::TOTAL_W-1:0];
                    end
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_total_reg <= total_reg;
                        out_ovf_reg   <= sat_reg;
                        total_reg     <= '0;
                        sat_reg       <= 1'b0;
                        have_prev_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_total_reg;
    assign m_tuser  = out_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && have_prev_reg |=> state_reg == ST_MUL)
        else $error("point with predecessor did not start the multiply sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_status.done |-> state_reg == ST_ROOT)
        else $error("square root finished outside the root state");

    assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> total_reg == '1)
        else $error("saturated total is not at maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '1)
        else $error("overflow flag set on a total below maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> !root_status.busy)
        else $error("square root unit busy during the multiply sequence");

endmodule

@@ tb/fepl_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// fepl_tb_pkg
// Point and path-total types plus the path ledger, which tracks the running
// flat-earth length of each path and checks the totals that the block reports.
// ----------------------------------------------------------------------------
package fepl_tb_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import fepl_pkg::*;

    localparam int FRAC_BITS   = 23;
    localparam int SCALE_SHIFT = FRAC_BITS - 2;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct {
        logic [LAT_W-1:0] latitude;
        logic [LON_W-1:0] longitude;
        logic             last_point;
    } track_point_t;

    typedef struct {
        logic [TOTAL_W-1:0] total_distance;
        logic               overflowed;
    } path_total_t;

    class path_ledger;

        logic [SCALE_W-1:0] lat_scale;
        logic [SCALE_W-1:0] lon_scale;
        logic [LAT_W-1:0]   prev_lat;
        logic [LON_W-1:0]   prev_lon;
        logic               have_prev;
        logic [TOTAL_W-1:0] total;
        logic               saturated;
        path_total_t        expected_totals[$];
        int                 errors;

        function new();
            lat_scale = '0;
            lon_scale = '0;
            prev_lat  = '0;
            prev_lon  = '0;
            have_prev = 1'b0;
            total     = '0;
            saturated = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [SCALE_W-1:0] value);
            case (index)
                CFG_LAT_SCALE: lat_scale = value;
                CFG_LON_SCALE: lon_scale = value;
                default: ;
            endcase
        endfunction

        // floor((cur - prev) * scale / 2^SCALE_SHIFT), signed
        function logic signed [63:0] scaled_offset(logic signed [63:0] cur,
                                                   logic signed [63:0] prev,
                                                   logic [SCALE_W-1:0] scale);
            logic signed [97:0] prod;
            prod = 98'(cur - prev) * 98'($signed({1'b0, scale}));
            return 64'(prod >>> SCALE_SHIFT);
        endfunction

        function logic [63:0] floor_root(logic [127:0] sq);
            logic [63:0]  root;
            logic [127:0] trial;
            int           i;
            root = '0;
            for (i = ROOT_W; i >= 0; i--)
            begin
                trial = 128'(root | (64'd1 << i));
                if (trial * trial <= sq)
                    root = trial[63:0];
            end
            return root;
        endfunction

        function void note_point(track_point_t pt);
            logic signed [63:0] dy;
            logic signed [63:0] dx;
            logic [127:0]       sq;
            logic [64:0]        sum;
            if (have_prev)
            begin
                dy  = scaled_offset($signed(pt.latitude), $signed(prev_lat), lat_scale);
                dx  = scaled_offset($signed(pt.longitude), $signed(prev_lon), lon_scale);
                sq  = 128'(dy) * 128'(dy) + 128'(dx) * 128'(dx);
                sum = {1'b0, total} + {1'b0, floor_root(sq)};
                if (sum[64])
                begin
                    total     = '1;
                    saturated = 1'b1;
                end
                else
                    total = sum[63:0];
            end
            prev_lat  = pt.latitude;
            prev_lon  = pt.longitude;
            have_prev = 1'b1;
            if (pt.last_point)
            begin
                expected_totals.push_back('{total, saturated});
                total     = '0;
                saturated = 1'b0;
                have_prev = 1'b0;
            end
        endfunction

        function int outstanding();
            return expected_totals.size();
        endfunction

        function void check_total(logic [TOTAL_W-1:0] got_total, logic ovf);
            path_total_t want;
            if (expected_totals.size() == 0)
            begin
                $display("%0t: unexpected total, expected none, got %h overflowed %b",
                         $time, got_total, ovf);
                errors++;
                return;
            end
            want = expected_totals.pop_front();
            if (got_total !== want.total_distance)
            begin
                $display("%0t: total_distance expected %h, got %h",
                         $time, want.total_distance, got_total);
                errors++;
            end
            if (ovf !== want.overflowed)
            begin
                $display("%0t: overflowed expected %b, got %b", $time, want.overflowed, ovf);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ tb/flat_earth_path_length_test.sv @@
// ----------------------------------------------------------------------------
// flat_earth_path_length_test
// Streams GNSS-style paths into the path length block under several scale
// settings, with bursty input and a stalling output, and checks every
// reported total against a bit-exact running prediction.
// ----------------------------------------------------------------------------
module flat_earth_path_length_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fepl_pkg::*;
    import fepl_tb_pkg::*;

    localparam logic [SCALE_W-1:0] LAT_SCALE_TYPICAL = 32'd1823866880;
    localparam logic [SCALE_W-1:0] LON_SCALE_TYPICAL = 32'd1289666560;
    localparam logic [LAT_W-1:0]   LAT_MAX     = 31'sd754974720;
    localparam logic [LAT_W-1:0]   LAT_MIN     = -31'sd754974720;
    localparam logic [LON_W-1:0]   LON_MAX     = 32'sd1509949440;
    localparam logic [LON_W-1:0]   LON_MIN     = -32'sd1509949440;
    localparam logic [LAT_W-1:0]   LAT_RAW_MIN = 31'h4000_0000;
    localparam logic [LAT_W-1:0]   LAT_RAW_MAX = 31'h3FFF_FFFF;
    localparam logic [LON_W-1:0]   LON_RAW_MIN = 32'h8000_0000;
    localparam logic [LON_W-1:0]   LON_RAW_MAX = 32'h7FFF_FFFF;
    localparam longint LAT_LIMIT     = 754974720;
    localparam longint LON_LIMIT     = 1509949440;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     PHASES        = 7;
    localparam int     PHASE_POINTS  = 255;

    typedef enum {READY_ALWAYS, READY_EVERY_THIRD, READY_COIN, READY_NEVER} ready_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic                 m_tuser;

    path_ledger   ledger;
    track_point_t cursor;
    int           points_sent;
    int           burst_left;
    logic         steady;

    flat_earth_path_length #(
        .COORD_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_total(m_tdata, m_tuser);
    end

    initial
    begin
        ready_mode_t mode;
        int          span;
        int          tick;
        m_tready = 1'b0;
        tick     = 0;
        forever
        begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = (mode == READY_NEVER) ? $urandom_range(20, 150) : $urandom_range(20, 400);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS:      m_tready <= 1'b1;
                    READY_EVERY_THIRD: m_tready <= (tick % 3 == 0);
                    READY_COIN:        m_tready <= 1'($urandom_range(0, 1));
                    default:           m_tready <= 1'b0;
                endcase
                tick++;
            end
        end
    end

    task automatic hold_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic pace_sender();
        if (steady)
            return;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 7) == 0)
                hold_sender($urandom_range(40, 90));
            else
                hold_sender($urandom_range(1, 8));
        end
    endtask

    task automatic send_point(input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon,
                              input logic last);
        track_point_t pt;
        pt.latitude   = lat;
        pt.longitude  = lon;
        pt.last_point = last;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, lon, lat};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_point(pt);
        cursor = pt;
        points_sent++;
        pace_sender();
    endtask

    // hold input until every reported total is back, then let the pipe settle
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SCALE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        ledger.write_reg(index, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_scales(input logic [SCALE_W-1:0] lat_s, input logic [SCALE_W-1:0] lon_s);
        drain_results();
        write_reg(CFG_UNUSED_A, $urandom);
        write_reg(CFG_LAT_SCALE, lat_s);
        write_reg(CFG_LON_SCALE, lon_s);
        write_reg(CFG_UNUSED_B, $urandom);
    endtask

    function automatic logic [LAT_W-1:0] rand_lat();
        longint v;
        v = longint'($urandom_range(0, 2 * LAT_LIMIT)) - LAT_LIMIT;
        return LAT_W'(v);
    endfunction

    function automatic logic [LON_W-1:0] rand_lon();
        longint v;
        v = longint'($urandom_range(0, 2 * LON_LIMIT)) - LON_LIMIT;
        return LON_W'(v);
    endfunction

    function automatic int nudge();
        int span;
        span = 1 << $urandom_range(0, 22);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_random_path();
        int               n;
        int               k;
        int               mode;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                lat = LAT_W'($urandom);
                lon = $urandom;
            end
            else if (mode < 3)
            begin
                lat = rand_lat();
                lon = rand_lon();
            end
            else
            begin
                lat = LAT_W'(cursor.latitude + nudge());
                lon = cursor.longitude + nudge();
            end
            send_point(lat, lon, k == n - 1);
        end
    endtask

    initial
    begin
        logic [SCALE_W-1:0] lat_set [PHASES];
        logic [SCALE_W-1:0] lon_set [PHASES];
        int                 phase;
        int                 phase_end;

        ledger      = new();
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_LAT_SCALE;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cursor      = '{'0, '0, 1'b0};
        points_sent = 0;
        burst_left  = 0;
        steady      = 1'b1;

        lat_set = '{'1, '0, LAT_SCALE_TYPICAL, 32'd1, $urandom, $urandom, LAT_SCALE_TYPICAL};
        lon_set = '{'1, LON_SCALE_TYPICAL, '0, 32'd1, $urandom, $urandom, LON_SCALE_TYPICAL};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // lone point at reset scales
        send_point(LAT_MAX, LON_MIN, 1'b1);

        set_scales(LAT_SCALE_TYPICAL, LON_SCALE_TYPICAL);
        send_point('0, '0, 1'b1);
        send_point(LAT_MAX, LON_MAX, 1'b0);
        send_point(LAT_MAX, LON_MAX, 1'b1);
        send_point(LAT_MIN, LON_MIN, 1'b0);
        send_point(LAT_MAX, LON_MAX, 1'b1);
        send_point(LAT_RAW_MIN, LON_RAW_MIN, 1'b0);
        send_point(LAT_RAW_MAX, LON_RAW_MAX, 1'b0);
        send_point(LAT_RAW_MIN, LON_RAW_MIN, 1'b1);
        // one-LSB steps down and back up: floor of a negative product
        send_point('0, '0, 1'b0);
        send_point('1, '1, 1'b0);
        send_point('0, '0, 1'b1);
        send_point(31'd1000, 32'd1000, 1'b0);
        send_point(31'd9000, 32'd1000, 1'b0);
        send_point(31'd9000, 32'd9000, 1'b0);
        send_point(31'd1000, 32'd9000, 1'b0);
        send_point(31'd1000, 32'd1000, 1'b1);

        set_scales('1, '1);
        send_point(LAT_RAW_MIN, LON_RAW_MIN, 1'b0);
        send_point(LAT_RAW_MAX, LON_RAW_MAX, 1'b1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            set_scales(lat_set[phase], lon_set[phase]);
            steady    = (phase == 2);
            phase_end = points_sent + PHASE_POINTS;
            while (points_sent < phase_end)
            begin
                send_random_path();
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (ledger.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
sv/fepl_pkg.sv
sv/fepl_mul.sv
sv/fepl_sqrt.sv
sv/flat_earth_path_length.sv
tb/fepl_tb_pkg.sv
tb/flat_earth_path_length_test.sv
